// ===== design/assert_macros.svh =====
// Concurrent assertion helpers; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property that must hold on every clock edge outside of reset.
`define BBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bbc assertion failed");
// Condition that must never be seen outside of reset.
`define BBC_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("bbc forbidden condition seen");
`else
`define BBC_ASSERT(lbl, prop)
`define BBC_ASSERT_NEVER(lbl, expr)
`endif

`endif

// ===== design/bbc_pkg.sv =====
`timescale 1ns / 1ps

package bbc_pkg;

  // Operation codes of a request beat
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2
  } op_e;

  // Status codes of a response beat
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNKNOWN  = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_COVERED  = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_e;

  // Per-cycle commands broadcast to every table cell
  typedef struct packed {
    logic cmp;   // latch cover / exact-match flags
    logic add;   // write new region into the cell at the fill point
    logic rem;   // shift down from the right neighbor past the removed entry
  } cell_ctrl_t;

endpackage

// ===== design/bbc_req_if.sv =====
`timescale 1ns / 1ps

interface bbc_req_if #(
  parameter int unsigned ADDR_BITS = 48,
  parameter int unsigned LEN_BITS  = 32
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [ADDR_BITS-1:0] address;
  logic [LEN_BITS-1:0]  length;

  modport source (output valid, operation, address, length, input ready);
  modport sink   (input valid, operation, address, length, output ready);
endinterface

// ===== design/bbc_rsp_if.sv =====
`timescale 1ns / 1ps

interface bbc_rsp_if #(
  parameter int unsigned LEN_BITS = 32,
  parameter int unsigned CNT_BITS = 5
);
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic [LEN_BITS-1:0] overrun_bytes;
  logic [CNT_BITS-1:0] entry_count;

  modport source (output valid, status, overrun_bytes, entry_count, input ready);
  modport sink   (input valid, status, overrun_bytes, entry_count, output ready);
endinterface

// ===== design/bbc_cell.sv =====
`timescale 1ns / 1ps

// One table slot: holds a region, compares it against the request and
// passes priority and shift data along the chain.
module bbc_cell #(
  parameter int unsigned ADDR_BITS = 48,
  parameter int unsigned END_W     = 49
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bbc_pkg::cell_ctrl_t   ctrl_i,
  input  logic                  active_i,
  input  logic                  write_sel_i,
  input  logic [ADDR_BITS-1:0]  addr_i,
  input  logic [END_W-1:0]      new_end_i,
  input  logic [ADDR_BITS-1:0]  nbr_start_i,
  input  logic [END_W-1:0]      nbr_end_i,
  input  logic                  cover_seen_i,
  input  logic                  exact_seen_i,
  input  logic [END_W-1:0]      end_bus_i,
  output logic [ADDR_BITS-1:0]  start_o,
  output logic [END_W-1:0]      end_o,
  output logic                  cover_seen_o,
  output logic                  exact_seen_o,
  output logic                  cover_first_o,
  output logic [END_W-1:0]      end_bus_o
);
  import bbc_pkg::*;

  logic [ADDR_BITS-1:0] start_q;
  logic [END_W-1:0]     end_q;
  logic                 cover_q;
  logic                 exact_q;
  logic                 shift_en;

  // Match flags, taken in the compare cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cover_q <= 1'b0;
      exact_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      cover_q <= active_i && (start_q <= addr_i) && (END_W'(addr_i) <= end_q);
      exact_q <= active_i && (start_q == addr_i);
    end
  end

  // Oldest-first priority ripples from cell 0 upward
  assign cover_first_o = cover_q && !cover_seen_i;
  assign cover_seen_o  = cover_seen_i || cover_q;
  assign exact_seen_o  = exact_seen_i || exact_q;
  assign end_bus_o     = end_bus_i | (cover_first_o ? end_q : '0);

  // Every cell at or past the removed entry takes its neighbor's region
  assign shift_en = ctrl_i.rem && (exact_seen_i || exact_q);

  // Region payload, no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.add && write_sel_i) begin
      start_q <= addr_i;
      end_q   <= new_end_i;
    end else if (shift_en) begin
      start_q <= nbr_start_i;
      end_q   <= nbr_end_i;
    end
  end

  assign start_o = start_q;
  assign end_o   = end_q;
endmodule

// ===== design/buffer_bounds_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Region bounds check table. Keeps up to ENTRIES registered regions in
// insertion order, one per cell of a chain; each holds a start and an
// inclusive end (start plus length). A request beat is accepted, every cell
// compares it against its region in the next cycle, and in the apply state
// the oldest match is picked along the chain, the table is updated (append,
// or shift-down over a removed entry) and the response is loaded into the
// output register. The apply state waits while the previous response is
// still unread. A new request is taken only once the block is idle again,
// even while the previous response still waits in the output register.
// There is no clearing pass after reset.
module buffer_bounds_checker #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned ADDR_BITS = 48,
  parameter int unsigned LEN_BITS  = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bbc_req_if.sink      req_i,
  bbc_rsp_if.source    rsp_o
);
  import bbc_pkg::*;

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned END_W = ((ADDR_BITS > LEN_BITS) ? ADDR_BITS : LEN_BITS) + 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d, res_count;
  logic [1:0]           op_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [END_W-1:0]     last_q;

  logic                 accept;
  logic                 advance;
  cell_ctrl_t           ctrl;

  logic [ADDR_BITS-1:0] start_w [ENTRIES];
  logic [END_W-1:0]     end_w   [ENTRIES];
  logic [ADDR_BITS-1:0] nbr_start [ENTRIES];
  logic [END_W-1:0]     nbr_end   [ENTRIES];
  logic                 cover_seen [ENTRIES+1];
  logic                 exact_seen [ENTRIES+1];
  logic [END_W-1:0]     end_bus    [ENTRIES+1];
  logic [ENTRIES-1:0]   cover_first;

  logic                 any_cover, any_exact, full, range_hit;
  logic [END_W-1:0]     sel_end;
  status_e              res_status;
  logic [LEN_BITS-1:0]  res_ovr;

  logic                 out_valid_q;
  status_e              out_status_q;
  logic [LEN_BITS-1:0]  out_ovr_q;
  logic [CNT_W-1:0]     out_count_q;

  // Handshake
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign advance     = (state_q == S_APPLY) && (!out_valid_q || rsp_o.ready);

  // Request capture; the access end is formed once here
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_i.operation;
      addr_q <= req_i.address;
      last_q <= END_W'(req_i.address) + END_W'(req_i.length);
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_CMP;
      S_CMP:   state_d = S_APPLY;
      S_APPLY: if (advance) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Cell chain
  assign cover_seen[0] = 1'b0;
  assign exact_seen[0] = 1'b0;
  assign end_bus[0]    = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == ENTRIES - 1) begin : g_tail
      assign nbr_start[i] = '0;
      assign nbr_end[i]   = '0;
    end else begin : g_body
      assign nbr_start[i] = start_w[i+1];
      assign nbr_end[i]   = end_w[i+1];
    end

    bbc_cell #(
      .ADDR_BITS (ADDR_BITS),
      .END_W     (END_W)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .active_i      (CNT_W'(i) < count_q),
      .write_sel_i   (CNT_W'(i) == count_q),
      .addr_i        (addr_q),
      .new_end_i     (last_q),
      .nbr_start_i   (nbr_start[i]),
      .nbr_end_i     (nbr_end[i]),
      .cover_seen_i  (cover_seen[i]),
      .exact_seen_i  (exact_seen[i]),
      .end_bus_i     (end_bus[i]),
      .start_o       (start_w[i]),
      .end_o         (end_w[i]),
      .cover_seen_o  (cover_seen[i+1]),
      .exact_seen_o  (exact_seen[i+1]),
      .cover_first_o (cover_first[i]),
      .end_bus_o     (end_bus[i+1])
    );
  end

  assign any_cover = cover_seen[ENTRIES];
  assign any_exact = exact_seen[ENTRIES];
  assign sel_end   = end_bus[ENTRIES];
  assign full      = (count_q == CNT_W'(ENTRIES));
  assign range_hit = (last_q > sel_end);

  // Resolve the operation and drive cell commands
  always_comb begin
    res_status = ST_OK;
    res_ovr    = '0;
    res_count  = count_q;
    ctrl       = '0;
    ctrl.cmp   = (state_q == S_CMP);
    unique case (op_q)
      OP_ADD: begin
        if (any_cover) begin
          res_status = ST_COVERED;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          ctrl.add  = advance;
          res_count = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!any_exact) begin
          res_status = ST_NOTFOUND;
        end else begin
          ctrl.rem  = advance;
          res_count = count_q - CNT_W'(1);
        end
      end
      OP_CHECK: begin
        if (!any_cover) begin
          res_status = ST_UNKNOWN;
        end else if (range_hit) begin
          res_status = ST_RANGE;
          res_ovr    = LEN_BITS'(last_q - sel_end);
        end
      end
      default: ;
    endcase
    count_d = advance ? res_count : count_q;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_status_q <= res_status;
      out_ovr_q    <= res_ovr;
      out_count_q  <= res_count;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.overrun_bytes = out_ovr_q;
  assign rsp_o.entry_count   = out_count_q;

  // Checks
  `BBC_ASSERT_NEVER(a_count_bound, count_q > CNT_W'(ENTRIES))
  `BBC_ASSERT(a_accept_to_cmp, accept |=> (state_q == S_CMP))
  `BBC_ASSERT(a_first_unique, $onehot0(cover_first))
  `BBC_ASSERT(a_count_only_on_apply, (state_q != S_APPLY) |=> (count_q == $past(count_q)))
  `BBC_ASSERT(a_range_has_overrun, (out_valid_q && (out_status_q == ST_RANGE)) |-> (out_ovr_q != '0))
endmodule

// ===== tb/buffer_bounds_checker_test.sv =====
`timescale 1ns / 1ps

module buffer_bounds_checker_test;
  import bbc_pkg::*;

  localparam int ENTRIES   = 16;
  localparam int ADDR_BITS = 48;
  localparam int LEN_BITS  = 32;
  localparam int CNT_BITS  = 5;

  localparam int CLK_HALF     = 5;
  localparam int N_RANDOM     = 1400;
  localparam int IDLE_LIMIT   = 3000;  // cycles with no beat on either side
  localparam int STALL_CYCLES = 400;   // long receiver hold-off
  localparam int HOLD_AFTER   = 300;   // results before the long hold-off
  localparam int DRAIN_CYCLES = 12;    // margin after the last response is taken

  // Unused operation code, acts as a no-op
  localparam logic [1:0] OP_NOP = 2'd3;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [ADDR_BITS:0]   end_t;
  typedef logic [LEN_BITS-1:0]  len_t;

  localparam addr_t ADDR_MAX   = '1;
  localparam len_t  LEN_MAX    = '1;
  localparam addr_t ROW_STRIDE = 48'h100;

  typedef struct packed {
    logic [2:0]          status;
    len_t                overrun;
    logic [CNT_BITS-1:0] count;
  } result_t;

  // Directed row: repeated reps times, address stepping by ROW_STRIDE.
  // When given is set the typed result is awaited instead of the predicted one.
  typedef struct packed {
    logic [1:0] op;
    addr_t      addr;
    len_t       len;
    logic [4:0] reps;
    logic       given;
    result_t    res;
  } stim_row_t;

  localparam int NUM_ROWS = 20;

  stim_row_t stim_rows [NUM_ROWS] = '{
    '{OP_CHECK,  48'h0,    32'h0,   5'd1,  1'b1, '{ST_UNKNOWN,  32'h0, 5'd0}},
    '{OP_REMOVE, 48'h0,    32'h0,   5'd1,  1'b1, '{ST_NOTFOUND, 32'h0, 5'd0}},
    '{OP_NOP,    ADDR_MAX, LEN_MAX, 5'd1,  1'b1, '{ST_OK,       32'h0, 5'd0}},
    '{OP_ADD,    48'h0,    32'h0,   5'd1,  1'b1, '{ST_OK,       32'h0, 5'd1}},
    '{OP_ADD,    48'h0,    32'h5,   5'd1,  1'b1, '{ST_COVERED,  32'h0, 5'd1}},
    '{OP_CHECK,  48'h0,    32'h1,   5'd1,  1'b1, '{ST_RANGE,    32'h1, 5'd1}},
    '{OP_ADD,    ADDR_MAX, LEN_MAX, 5'd1,  1'b1, '{ST_OK,       32'h0, 5'd2}},
    '{OP_CHECK,  ADDR_MAX, LEN_MAX, 5'd1,  1'b1, '{ST_OK,       32'h0, 5'd2}},
    '{OP_ADD,    48'h64,   32'd10,  5'd1,  1'b1, '{ST_OK,       32'h0, 5'd3}},
    '{OP_CHECK,  48'h6E,   32'h0,   5'd1,  1'b1, '{ST_OK,       32'h0, 5'd3}},
    '{OP_CHECK,  48'h69,   LEN_MAX, 5'd1,  1'b1, '{ST_RANGE, 32'hFFFF_FFFA, 5'd3}},
    '{OP_ADD,    48'h6E,   32'h1,   5'd1,  1'b1, '{ST_COVERED,  32'h0, 5'd3}},
    '{OP_ADD,    48'h6F,   32'h0,   5'd1,  1'b1, '{ST_OK,       32'h0, 5'd4}},
    '{OP_REMOVE, 48'h64,   LEN_MAX, 5'd1,  1'b1, '{ST_OK,       32'h0, 5'd3}},
    '{OP_CHECK,  48'h69,   32'h0,   5'd1,  1'b1, '{ST_UNKNOWN,  32'h0, 5'd3}},
    '{OP_REMOVE, 48'h64,   32'h0,   5'd1,  1'b1, '{ST_NOTFOUND, 32'h0, 5'd3}},
    // fill the table up to the last entry
    '{OP_ADD,    48'h1000, 32'hF,   5'd13, 1'b0, '{ST_OK,       32'h0, 5'd0}},
    '{OP_ADD,    48'h9000, 32'h0,   5'd1,  1'b1, '{ST_FULL,     32'h0, 5'd16}},
    // covered start wins over a full table
    '{OP_ADD,    48'h1105, 32'h0,   5'd1,  1'b1, '{ST_COVERED,  32'h0, 5'd16}},
    '{OP_REMOVE, 48'h1500, 32'h0,   5'd1,  1'b1, '{ST_OK,       32'h0, 5'd15}}
  };

  logic clk_i;
  logic rst_ni;

  bbc_req_if #(.ADDR_BITS(ADDR_BITS), .LEN_BITS(LEN_BITS)) req ();
  bbc_rsp_if #(.LEN_BITS(LEN_BITS), .CNT_BITS(CNT_BITS)) rsp ();

  buffer_bounds_checker #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS),
    .LEN_BITS  (LEN_BITS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Predicted region table
  addr_t tbl_start [ENTRIES];
  end_t  tbl_end [ENTRIES];
  int    tbl_used;

  result_t     awaited_results [$];
  int unsigned status_tally [8];
  int unsigned errors;
  int unsigned results_seen;
  int unsigned beats_sent;
  int unsigned idle_cycles;
  bit          no_idle;
  bit          long_hold_done;

  initial clk_i = 1'b0;
  always #CLK_HALF clk_i = ~clk_i;

  // Oldest region whose inclusive span holds a, or -1
  function automatic int covering_slot(addr_t a);
    int i;
    for (i = 0; i < tbl_used; i++) begin
      if (tbl_start[i] <= a && end_t'(a) <= tbl_end[i]) return i;
    end
    return -1;
  endfunction

  // Applies one request to the predicted table and returns its response
  function automatic result_t region_table_step(logic [1:0] op, addr_t a, len_t l);
    result_t r;
    int      i;
    int      hit;
    end_t    last;
    r.status  = ST_OK;
    r.overrun = '0;
    hit       = -1;
    case (op)
      OP_ADD: begin
        if (covering_slot(a) >= 0) begin
          r.status = ST_COVERED;
        end else if (tbl_used >= ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          tbl_start[tbl_used] = a;
          tbl_end[tbl_used]   = end_t'(a) + end_t'(l);
          tbl_used++;
        end
      end
      OP_REMOVE: begin
        for (i = 0; i < tbl_used; i++) begin
          if (hit < 0 && tbl_start[i] == a) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          // close the gap, keeping insertion order
          for (i = hit; i + 1 < tbl_used; i++) begin
            tbl_start[i] = tbl_start[i+1];
            tbl_end[i]   = tbl_end[i+1];
          end
          tbl_used--;
        end
      end
      OP_CHECK: begin
        hit = covering_slot(a);
        if (hit < 0) begin
          r.status = ST_UNKNOWN;
        end else begin
          last = end_t'(a) + end_t'(l);
          if (last > tbl_end[hit]) begin
            r.status  = ST_RANGE;
            r.overrun = len_t'(last - tbl_end[hit]);
          end
        end
      end
      default: ;
    endcase
    r.count = tbl_used[CNT_BITS-1:0];
    return r;
  endfunction

  // Mostly back-to-back, sometimes short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Addresses cluster in three windows and around registered regions, with some fully random
  function automatic addr_t pick_addr();
    int          r;
    int          k;
    logic [63:0] wide;
    addr_t       base;
    r = $urandom_range(0, 9);
    if (r < 4 && tbl_used > 0) begin
      k = $urandom_range(0, tbl_used - 1);
      case ($urandom_range(0, 4))
        0: return tbl_start[k];
        1: return tbl_start[k] - addr_t'(1);
        2: return tbl_end[k][ADDR_BITS-1:0];
        3: return tbl_end[k][ADDR_BITS-1:0] + addr_t'(1);
        default: return tbl_start[k] + addr_t'($urandom_range(0, 255));
      endcase
    end
    if (r == 9) begin
      wide = {$urandom, $urandom};
      return wide[ADDR_BITS-1:0];
    end
    case ($urandom_range(0, 2))
      0: base = '0;
      1: base = 48'h5A5A_A5A5_0000;
      default: base = ADDR_MAX - 48'hFFFF;
    endcase
    return base + addr_t'($urandom_range(0, 'h3FFF));
  endfunction

  function automatic len_t pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return len_t'($urandom_range(0, 'h1FF));
    if (r < 16) return len_t'($urandom_range(0, 'hFFFF));
    if (r < 18) return len_t'($urandom);
    return (r == 18) ? '0 : LEN_MAX;
  endfunction

  // Drives one request beat, holds it until taken, then records the response
  // it must produce. Entered and left at a rising edge.
  task automatic offer(logic [1:0] op, addr_t a, len_t l, logic given, result_t typed);
    int      gap;
    result_t pred;
    gap = idle_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.address   <= a;
    req.length    <= l;
    do @(posedge clk_i); while (!req.ready);
    pred = region_table_step(op, a, l);
    if (given) pred = typed;
    awaited_results = {awaited_results, pred};
    status_tally[pred.status]++;
    beats_sent++;
  endtask

  // Response comparison
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d overrun=%0h count=%0d", $time,
                 rsp.status, rsp.overrun_bytes, rsp.entry_count);
      end else begin
        want = awaited_results.pop_front();
        if (rsp.status !== want.status || rsp.overrun_bytes !== want.overrun ||
            rsp.entry_count !== want.count) begin
          errors++;
          $display("%0t: mismatch expected status=%0d overrun=%0h count=%0d", $time,
                   want.status, want.overrun, want.count);
          $display("%0t:          actual   status=%0d overrun=%0h count=%0d", $time,
                   rsp.status, rsp.overrun_bytes, rsp.entry_count);
        end
      end
    end
  end

  // Watchdog: no beat on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat taken for %0d cycles, %0d results still awaited", $time,
                 idle_cycles, awaited_results.size());
        $display("buffer_bounds_checker_test: errors");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, once a long hold-off
  initial begin : ready_driver
    int gap;
    rsp.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (results_seen >= HOLD_AFTER && !long_hold_done) begin
        long_hold_done = 1'b1;
        rsp.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk_i);
      end else begin
        gap = idle_gap();
        if (gap > 0) begin
          rsp.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      rsp.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  // Sender: directed rows, then random traffic
  initial begin : stimulus
    int         i;
    int         n;
    int         rep;
    int         cut;
    int         r;
    logic [1:0] op;
    addr_t      a;
    len_t       l;
    rst_ni        <= 1'b0;
    req.valid     <= 1'b0;
    req.operation <= OP_ADD;
    req.address   <= '0;
    req.length    <= '0;
    tbl_used = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < NUM_ROWS; i++) begin
      for (rep = 0; rep < stim_rows[i].reps; rep++) begin
        offer(stim_rows[i].op, stim_rows[i].addr + addr_t'(rep) * ROW_STRIDE,
              stim_rows[i].len, stim_rows[i].given, stim_rows[i].res);
      end
    end

    for (n = 0; n < N_RANDOM; n++) begin
      // a stretch with no gaps on either side
      if (n == 400) no_idle = 1'b1;
      if (n == 600) no_idle = 1'b0;
      // let the block run dry once
      if (n == 800) begin
        req.valid <= 1'b0;
        @(posedge clk_i);
        wait (awaited_results.size() == 0);
        @(posedge clk_i);
      end
      // fewer adds when the table is full
      cut = (tbl_used == ENTRIES) ? 20 : 45;
      r   = $urandom_range(0, 99);
      if (r < cut) op = OP_ADD;
      else if (r < cut + 22) op = OP_REMOVE;
      else if (r < 96) op = OP_CHECK;
      else op = OP_NOP;
      a = pick_addr();
      l = pick_len();
      if (op == OP_REMOVE && tbl_used > 0 && $urandom_range(0, 9) < 7) begin
        a = tbl_start[$urandom_range(0, tbl_used - 1)];
      end
      offer(op, a, l, 1'b0, '0);
    end

    req.valid <= 1'b0;
    @(posedge clk_i);
    wait (awaited_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d request beats, %0d responses checked, one %0d-cycle receiver hold-off",
             beats_sent, results_seen, STALL_CYCLES);
    $display("status mix: ok %0d, unknown %0d, out of range %0d, full %0d, covered %0d, %s %0d",
             status_tally[ST_OK], status_tally[ST_UNKNOWN], status_tally[ST_RANGE],
             status_tally[ST_FULL], status_tally[ST_COVERED], "not found",
             status_tally[ST_NOTFOUND]);
    if (errors == 0) begin
      $display("buffer_bounds_checker_test: clean");
    end else begin
      $display("buffer_bounds_checker_test: errors");
    end
    $finish;
  end

endmodule
